FILE: hdl/vvg_pkg.sv
// ----------------------------------------------------------------------------
// vvg_pkg: shared types and constants of the Verlet gravity step
// Fixed-point vector types, status flags, register codes, pipeline depths
// and the output clamp.
// ----------------------------------------------------------------------------
package vvg_pkg;

  // three 48-bit components, x in the lowest bits
  typedef logic [2:0][47:0] vec3_t;

  typedef struct packed {
    logic sat;
    logic sing;
  } kick_flags_t;

  // configuration register index (byte address bit 3)
  typedef enum logic {
    REG_GM = 1'b0,
    REG_TS = 1'b1
  } reg_idx_t;

  localparam logic [63:0] GM_RST = 64'd26122387456;
  localparam logic [31:0] TS_RST = 32'd65536;

  // limit of one velocity increment
  localparam logic [50:0] D_CAP = 51'd1 << 50;

  localparam logic signed [51:0] FIX_MAX = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] FIX_MIN = -52'sh0_8000_0000_0000;

  // pipeline depths; a multiplier takes one 32x32 chunk product per stage
  localparam int SQ_LAT   = 4;              // 48x48 square, 2x2 chunks
  localparam int SQRT_W   = 49;             // one root bit per stage
  localparam int NUM_LAT  = 6;              // 96x48 numerator, 3x2 chunks
  localparam int PROD_LAT = 8;              // 98x49 denominator, 4x2 chunks
  localparam int DMUL_LAT = 2;              // 48x32 drift product, 2x1 chunks
  localparam int QUO_W    = 52;             // quotient bits 51..0
  localparam int DIV_LAT  = QUO_W + 1;      // range check plus one bit per stage
  localparam int KICK_LAT = 1 + SQ_LAT + 1 + SQRT_W + PROD_LAT + DIV_LAT + 1;
  localparam int DRIFT_LAT = 1 + DMUL_LAT + 1;

  // clamp to the 48-bit signed range; msb of the result flags a clamp
  function automatic logic [48:0] clamp_fix(input logic signed [51:0] x);
    logic [48:0] res;
    if (x > FIX_MAX) begin
      res = {1'b1, FIX_MAX[47:0]};
    end else if (x < FIX_MIN) begin
      res = {1'b1, FIX_MIN[47:0]};
    end else begin
      res = {1'b0, x[47:0]};
    end
    return res;
  endfunction

endpackage

FILE: hdl/vvg_pipe.sv
// ----------------------------------------------------------------------------
// vvg_pipe: delay line
// Carries side data alongside an arithmetic unit, advancing on clock enable.
// ----------------------------------------------------------------------------
module vvg_pipe #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [0:D-1];

  // advance all taps together
  always_ff @(posedge clk) begin
    if (ce) begin
      tap_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[D-1];

endmodule

FILE: hdl/vvg_mul.sv
// ----------------------------------------------------------------------------
// vvg_mul: pipelined unsigned multiplier
// Each stage adds one 32x32 chunk product, A chunks inner, B chunks outer.
// ----------------------------------------------------------------------------
module vvg_mul #(
  parameter int WA = 64,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA  = (WA + 31) / 32;
  localparam int NB  = (WB + 31) / 32;
  localparam int NS  = NA * NB;
  localparam int WAP = NA * 32;
  localparam int WBP = NB * 32;
  localparam int WP  = WAP + WBP;

  logic [WAP-1:0] a_r   [0:NS-1];
  logic [WBP-1:0] b_r   [0:NS-1];
  logic [WP-1:0]  acc_r [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    localparam int KA = s % NA;
    localparam int KB = s / NA;
    logic [WAP-1:0] a_in;
    logic [WBP-1:0] b_in;
    logic [WP-1:0]  acc_in;
    logic [63:0]    pp;

    if (s == 0) begin : g_first
      assign a_in   = WAP'(a);
      assign b_in   = WBP'(b);
      assign acc_in = '0;
    end else begin : g_rest
      assign a_in   = a_r[s-1];
      assign b_in   = b_r[s-1];
      assign acc_in = acc_r[s-1];
    end

    // one chunk product per stage
    assign pp = 64'(a_in[32*KA +: 32]) * 64'(b_in[32*KB +: 32]);

    always_ff @(posedge clk) begin
      if (ce) begin
        a_r[s]   <= a_in;
        b_r[s]   <= b_in;
        acc_r[s] <= acc_in + (WP'(pp) << (32 * (KA + KB)));
      end
    end
  end

  assign p = acc_r[NS-1][WA+WB-1:0];

endmodule

FILE: hdl/vvg_isqrt.sv
// ----------------------------------------------------------------------------
// vvg_isqrt: pipelined integer square root
// Floor of the square root, one result bit per stage by the digit method.
// ----------------------------------------------------------------------------
module vvg_isqrt #(
  parameter int WQ = 98,
  parameter int WS = 49
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [WQ-1:0] q,
  output logic [WS-1:0] s
);

  localparam int WR = WQ + 2;

  logic [WR-1:0] rem_r [0:WS-1];
  logic [WS-1:0] res_r [0:WS-1];

  for (genvar j = 0; j < WS; j++) begin : g_stg
    localparam int K = WS - 1 - j;
    logic [WR-1:0] rin;
    logic [WS-1:0] sin;
    logic [WR-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rin = WR'(q);
      assign sin = '0;
    end else begin : g_rest
      assign rin = rem_r[j-1];
      assign sin = res_r[j-1];
    end

    // (2*res + 2^k) * 2^k against the remainder
    assign trial = (WR'(sin) << (K + 1)) + (WR'(1) << (2 * K));
    assign ge    = (rin >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j] <= ge ? rin - trial : rin;
        res_r[j] <= ge ? (sin | (WS'(1) << K)) : sin;
      end
    end
  end

  assign s = res_r[WS-1];

endmodule

FILE: hdl/vvg_div.sv
// ----------------------------------------------------------------------------
// vvg_div: pipelined restoring divider
// First stage flags a quotient of 2^WQ or more, then one quotient bit per
// stage from the top.
// ----------------------------------------------------------------------------
module vvg_div #(
  parameter int WN = 180,
  parameter int WD = 148,
  parameter int WQ = 52
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  output logic [WQ-1:0] quo,
  output logic          ovf
);

  localparam int WR = (WN > WD + WQ) ? WN : WD + WQ;

  logic [WR-1:0] rem_r [0:WQ];
  logic [WD-1:0] den_r [0:WQ];
  logic [WQ-1:0] quo_r [0:WQ];
  logic          ovf_r [0:WQ];

  // range check
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= WR'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= (WR'(num) >= (WR'(den) << WQ));
    end
  end

  for (genvar j = 0; j < WQ; j++) begin : g_stg
    localparam int K = WQ - 1 - j;
    logic [WR-1:0] trial;
    logic          ge;

    assign trial = WR'(den_r[j]) << K;
    assign ge    = (rem_r[j] >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j+1] <= ge ? rem_r[j] - trial : rem_r[j];
        den_r[j+1] <= den_r[j];
        quo_r[j+1] <= ge ? (quo_r[j] | (WQ'(1) << K)) : quo_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  assign quo = quo_r[WQ];
  assign ovf = ovf_r[WQ];

endmodule

FILE: hdl/vvg_kick.sv
// ----------------------------------------------------------------------------
// vvg_kick: half-step velocity update under point-mass gravity
// dv = |r| * gm * dt * 2^36 / (2 * q * sqrt(q)), signed as r, capped, added
// and clamped. Zero distance leaves the velocity and marks singular.
// ----------------------------------------------------------------------------
module vvg_kick (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [95:0]          fac,
  input  vvg_pkg::vec3_t       c_i,
  input  vvg_pkg::vec3_t       p_i,
  input  vvg_pkg::vec3_t       v_i,
  input  vvg_pkg::kick_flags_t flg_i,
  output vvg_pkg::vec3_t       c_o,
  output vvg_pkg::vec3_t       p_o,
  output vvg_pkg::vec3_t       v_o,
  output vvg_pkg::kick_flags_t flg_o
);

  import vvg_pkg::*;

  typedef struct packed {
    vec3_t       c;
    vec3_t       p;
    vec3_t       v;
    kick_flags_t flg;
  } kick_bun_t;

  typedef struct packed {
    kick_bun_t        bun;
    logic [2:0]       neg;
    logic [2:0][47:0] m;
  } kick_geo_t;

  typedef struct packed {
    kick_bun_t  bun;
    logic [2:0] neg;
    logic       zero;
  } kick_tail_t;

  // stage 0: offset to the center and its magnitude
  logic [2:0][47:0] m_w;
  logic [2:0]       neg_w;
  logic [2:0][47:0] m_r;
  logic [2:0]       neg_r;
  kick_bun_t        bun0_r;

  for (genvar i = 0; i < 3; i++) begin : g_off
    logic signed [48:0] r;
    logic [48:0]        rn;
    assign r        = {c_i[i][47], c_i[i]} - {p_i[i][47], p_i[i]};
    assign rn       = 49'd0 - r;
    assign neg_w[i] = r[48];
    assign m_w[i]   = r[48] ? rn[47:0] : r[47:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_r    <= m_w;
      neg_r  <= neg_w;
      bun0_r <= '{c: c_i, p: p_i, v: v_i, flg: flg_i};
    end
  end

  // squares
  logic [95:0] sq_w [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_sq
    vvg_mul #(.WA(48), .WB(48)) u_sq (
      .clk (clk), .ce (ce), .a (m_r[i]), .b (m_r[i]), .p (sq_w[i])
    );
  end

  kick_geo_t geo_a;
  vvg_pipe #(.W($bits(kick_geo_t)), .D(SQ_LAT)) u_pipe_a (
    .clk (clk), .ce (ce), .din ({bun0_r, neg_r, m_r}), .dout (geo_a)
  );

  // squared distance
  logic [97:0] q_r;
  kick_geo_t   geo_q_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      q_r     <= 98'(sq_w[0]) + 98'(sq_w[1]) + 98'(sq_w[2]);
      geo_q_r <= geo_a;
    end
  end

  // distance
  logic [48:0] s_w;
  vvg_isqrt #(.WQ(98), .WS(SQRT_W)) u_sqrt (
    .clk (clk), .ce (ce), .q (q_r), .s (s_w)
  );

  logic [97:0] q_b;
  kick_geo_t   geo_b;
  vvg_pipe #(.W($bits(kick_geo_t) + 98), .D(SQRT_W)) u_pipe_b (
    .clk (clk), .ce (ce), .din ({geo_q_r, q_r}), .dout ({geo_b, q_b})
  );

  // denominator q*s and numerators |r|*gm*dt
  logic [146:0] den_w;
  logic [143:0] num_w [0:2];
  logic [143:0] num_d [0:2];

  vvg_mul #(.WA(98), .WB(49)) u_den (
    .clk (clk), .ce (ce), .a (q_b), .b (s_w), .p (den_w)
  );

  // numerators finish early; delay them to meet the denominator
  for (genvar i = 0; i < 3; i++) begin : g_num
    vvg_mul #(.WA(96), .WB(48)) u_num (
      .clk (clk), .ce (ce), .a (fac), .b (geo_b.m[i]), .p (num_w[i])
    );
    vvg_pipe #(.W(144), .D(PROD_LAT - NUM_LAT)) u_num_dly (
      .clk (clk), .ce (ce), .din (num_w[i]), .dout (num_d[i])
    );
  end

  kick_tail_t tail_c;
  vvg_pipe #(.W($bits(kick_tail_t)), .D(PROD_LAT)) u_pipe_c (
    .clk (clk), .ce (ce), .din ({geo_b.bun, geo_b.neg, q_b == 98'd0}), .dout (tail_c)
  );

  // quotients
  logic [QUO_W-1:0] quo_w [0:2];
  logic [2:0]       ovf_w;
  for (genvar i = 0; i < 3; i++) begin : g_div
    vvg_div #(.WN(180), .WD(148), .WQ(QUO_W)) u_div (
      .clk (clk), .ce (ce),
      .num ({num_d[i], 36'd0}), .den ({den_w, 1'b0}),
      .quo (quo_w[i]), .ovf (ovf_w[i])
    );
  end

  kick_tail_t tail_d;
  vvg_pipe #(.W($bits(kick_tail_t)), .D(DIV_LAT)) u_pipe_d (
    .clk (clk), .ce (ce), .din (tail_c), .dout (tail_d)
  );

  // cap, add and clamp
  vec3_t      vn_w;
  logic [2:0] sat_w;
  for (genvar i = 0; i < 3; i++) begin : g_upd
    logic              cap;
    logic [50:0]       d;
    logic signed [51:0] ve;
    logic signed [51:0] de;
    logic [48:0]       cl;
    assign cap = ovf_w[i] || (quo_w[i] > {1'b0, D_CAP});
    assign d   = cap ? D_CAP : quo_w[i][50:0];
    assign ve  = {{4{tail_d.bun.v[i][47]}}, tail_d.bun.v[i]};
    assign de  = {1'b0, d};
    assign cl  = clamp_fix(tail_d.neg[i] ? ve - de : ve + de);
    assign vn_w[i]  = tail_d.zero ? tail_d.bun.v[i] : cl[47:0];
    assign sat_w[i] = !tail_d.zero && (cap || cl[48]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_o        <= tail_d.bun.c;
      p_o        <= tail_d.bun.p;
      v_o        <= vn_w;
      flg_o.sing <= tail_d.bun.flg.sing || tail_d.zero;
      flg_o.sat  <= tail_d.bun.flg.sat || (|sat_w);
    end
  end

endmodule

FILE: hdl/velocity_verlet_gravity_step.sv
// ----------------------------------------------------------------------------
// velocity_verlet_gravity_step: kick-drift-kick step under point-mass gravity
// Advances one body per item; the central position comes with each item.
//
// Input stream in_*: one body per transfer (center, position, velocity).
// Output stream out_*: new position and velocity, plus singular and
// saturated status in out_tuser.
// APB port cfg_*: gm at byte 0x0 (64 bit), time_step at byte 0x8 (32 bit).
// Write registers only while no item is in flight.
//
// The pipeline is two kicks of 117 stages and a 4-stage drift. Each
// kick holds its 49-stage square root and 53-stage divider.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls the whole pipeline holds and in_tready drops;
// in_tready follows out_tready while a result is waiting.
// Reset clears all valid bits and loads the register defaults
// (gm 26122387456, time_step 65536). gm*time_step comes from a pipelined
// multiplier and so lags a write.
// ----------------------------------------------------------------------------
module velocity_verlet_gravity_step (
  input  logic          clk,
  input  logic          rst_n,
  // stream in
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [431:0]  in_tdata,  // center_x/y/z, pos_x/y/z, vel_x/y/z (48 b)
  // stream out
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [287:0]  out_tdata, // new_pos_x/y/z, new_vel_x/y/z (48 b)
  output logic [1:0]    out_tuser, // singular, saturated
  // configuration
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [63:0]   cfg_pwdata,
  output logic [63:0]   cfg_prdata,
  output logic          cfg_pready
);

  import vvg_pkg::*;

  localparam int LAT = 2 * KICK_LAT + DRIFT_LAT;

  // configuration registers
  logic [63:0] gm_r;
  logic [31:0] ts_r;
  reg_idx_t    cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r <= GM_RST;
      ts_r <= TS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_GM:  gm_r <= cfg_pwdata;
        REG_TS:  ts_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GM:  cfg_prdata = gm_r;
      REG_TS:  cfg_prdata = {32'd0, ts_r};
      default: cfg_prdata = '0;
    endcase
  end

  // gm * dt, shared by both kicks
  logic [95:0] fac_w;
  vvg_mul #(.WA(64), .WB(32)) u_fac (
    .clk (clk), .ce (1'b1), .a (gm_r), .b (ts_r), .p (fac_w)
  );

  // pipeline advance and valid bits
  logic           ce;
  logic [LAT-1:0] vld_r;

  assign ce         = !out_tvalid || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // first kick
  vec3_t       c1, p1, v1;
  kick_flags_t f1;
  vvg_kick u_kick1 (
    .clk (clk), .ce (ce), .fac (fac_w),
    .c_i (in_tdata[143:0]), .p_i (in_tdata[287:144]), .v_i (in_tdata[431:288]),
    .flg_i ('0),
    .c_o (c1), .p_o (p1), .v_o (v1), .flg_o (f1)
  );

  // drift: magnitude of the half-step velocity
  logic [2:0][47:0] vm_r;
  logic [2:0]       vneg_r, vneg1;
  vec3_t            dc0_r, dp0_r, dv0_r, dc1, dp1, dv1;
  kick_flags_t      df0_r, df1;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        vm_r[i]   <= v1[i][47] ? 48'd0 - v1[i] : v1[i];
        vneg_r[i] <= v1[i][47];
      end
      dc0_r <= c1;
      dp0_r <= p1;
      dv0_r <= v1;
      df0_r <= f1;
    end
  end

  // drift: |v| * dt
  logic [79:0] dprod_w [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_drift
    vvg_mul #(.WA(48), .WB(32)) u_dmul (
      .clk (clk), .ce (ce), .a (vm_r[i]), .b (ts_r), .p (dprod_w[i])
    );
  end

  // carry side data alongside the drift product
  vvg_pipe #(.W(3 + 3 * $bits(vec3_t) + $bits(kick_flags_t)), .D(DMUL_LAT)) u_dpipe (
    .clk (clk), .ce (ce),
    .din ({vneg_r, dc0_r, dp0_r, dv0_r, df0_r}),
    .dout ({vneg1, dc1, dp1, dv1, df1})
  );

  // drift: move and clamp
  vec3_t      pn_w;
  logic [2:0] dsat_w;
  for (genvar i = 0; i < 3; i++) begin : g_move
    logic signed [51:0] pe;
    logic signed [51:0] de;
    logic [48:0]        cl;
    assign pe        = {{4{dp1[i][47]}}, dp1[i]};
    assign de        = {8'd0, dprod_w[i][79:36]};
    assign cl        = clamp_fix(vneg1[i] ? pe - de : pe + de);
    assign pn_w[i]   = cl[47:0];
    assign dsat_w[i] = cl[48];
  end

  vec3_t       c2_r, p2_r, v2_r;
  kick_flags_t f2_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      c2_r      <= dc1;
      p2_r      <= pn_w;
      v2_r      <= dv1;
      f2_r.sing <= df1.sing;
      f2_r.sat  <= df1.sat || (|dsat_w);
    end
  end

  // second kick, registers drive the output
  vec3_t       po, vo;
  kick_flags_t fo;
  vvg_kick u_kick2 (
    .clk (clk), .ce (ce), .fac (fac_w),
    .c_i (c2_r), .p_i (p2_r), .v_i (v2_r), .flg_i (f2_r),
    .c_o (), .p_o (po), .v_o (vo), .flg_o (fo)
  );

  assign out_tdata = {vo, po};
  assign out_tuser = {fo.sat, fo.sing};

`ifndef SYNTHESIS
  // valid count tracks input and output transfers
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r))
      + int'($past(in_tvalid && in_tready)) - int'($past(out_tvalid && out_tready))))
    else $error("valid bits out of step with transfers");

  // a stall freezes every valid bit
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(ce) |-> (vld_r == $past(vld_r)))
    else $error("pipeline moved during a stall");

  // no item can enter while the held result is refused
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
`endif

endmodule
